### rtl/csht_pkg.sv
package csht_pkg;

   localparam int SLOT_BITS  = 10;
   localparam int COUNT_BITS = SLOT_BITS + 1;
   localparam int KEY_BITS   = 64;
   localparam int VAL_BITS   = 64;
   localparam int LOG2_BITS  = 4;
   localparam int STEP_BITS  = 5;

   localparam logic [LOG2_BITS-1:0] MIN_LOG2 = 4'd2;
   localparam logic [LOG2_BITS-1:0] MAX_LOG2 = LOG2_BITS'(SLOT_BITS);

   localparam logic [1:0] CMD_GET   = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_TRAV  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ABSENT   = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BAD_KEY  = 3'd3;
   localparam logic [2:0] ST_TRAV_END = 3'd4;

   typedef struct packed {
      logic                 used;
      logic                 present;
      logic                 has_next;
      logic [SLOT_BITS-1:0] next;
   } meta_type;

   typedef struct packed {
      logic                 we_key;
      logic                 we_val;
      logic                 we_meta;
      logic [SLOT_BITS-1:0] addr;
      logic [KEY_BITS-1:0]  key;
      logic [VAL_BITS-1:0]  val;
      meta_type             meta;
   } mem_req_type;

endpackage

### rtl/csht_table.sv
module csht_table (
   input  logic                  clock,
   input  csht_pkg::mem_req_type req,
   output logic [63:0]           q_key,
   output logic [63:0]           q_val,
   output csht_pkg::meta_type    q_meta
);
   import csht_pkg::*;

   localparam int DEPTH = 1 << SLOT_BITS;

   logic [KEY_BITS-1:0] key_mem [DEPTH];
   logic [VAL_BITS-1:0] val_mem [DEPTH];
   meta_type            meta_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (req.we_key) begin
         key_mem[req.addr] <= req.key;
      end
      if (req.we_val) begin
         val_mem[req.addr] <= req.val;
      end
      if (req.we_meta) begin
         meta_mem[req.addr] <= req.meta;
      end
      q_key  <= key_mem[req.addr];
      q_val  <= val_mem[req.addr];
      q_meta <= meta_mem[req.addr];
   end

endmodule

### rtl/csht_fold.sv
module csht_fold (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [63:0]                      key,
   input  logic [csht_pkg::LOG2_BITS-1:0]   size_log2,
   output logic                             done,
   output logic [csht_pkg::SLOT_BITS-1:0]   home
);
   import csht_pkg::*;

   // key mod (2^s - 1): add s-bit digits with end-around carry
   logic                 busy_ff, busy_in;
   logic [KEY_BITS-1:0]  rem_ff, rem_in;
   logic [SLOT_BITS-1:0] acc_ff, acc_in;
   logic [SLOT_BITS-1:0] mask;
   logic [SLOT_BITS:0]   sum;
   logic [SLOT_BITS:0]   folded;

   assign mask   = SLOT_BITS'((COUNT_BITS'(1) << size_log2) - COUNT_BITS'(1));
   assign sum    = {1'b0, acc_ff} + {1'b0, rem_ff[SLOT_BITS-1:0] & mask};
   assign folded = {1'b0, sum[SLOT_BITS-1:0] & mask} + COUNT_BITS'(sum >> size_log2);
   assign done   = busy_ff && (rem_ff == '0);
   assign home   = (acc_ff == mask) ? '0 : acc_ff;

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = key;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            rem_in = rem_ff >> size_log2;
            acc_in = folded[SLOT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

endmodule

### rtl/chained_scatter_hash_table.sv
// Channel  Direction  Handshake           Carries
// req_     in         valid / stall       command, key, value, value_present, start_req
// rsp_     out        valid / stall       status, key_out, value_out, live_count
// csr_     in         valid / ready       size_log2 (write also empties the table)
//
// One item at a time. The home slot comes from the digit-fold unit, then each slot is read
// from the single-port slot memory in a read state and a check state: chain walk, free-slot
// scan and traversal scan each read one slot per step, and inserts add up to 3 writes.
// Reset, clear and a size write sweep the slot metadata, one slot per cycle
// (2^size_log2 slots, all 1024 after reset); no item is taken meanwhile.
// A finished item waits in the rsp_ register while the next item is taken.
module chained_scatter_hash_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_command,
   input  logic signed [63:0]               req_key,
   input  logic [63:0]                      req_value,
   input  logic                             req_value_present,
   input  logic                             req_start_req,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_status,
   output logic signed [63:0]               rsp_key_out,
   output logic [63:0]                      rsp_value_out,
   output logic [10:0]                      rsp_live_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [csht_pkg::LOG2_BITS-1:0]   csr_size_log2
);
   import csht_pkg::*;

   localparam logic [4:0] S_SWEEP     = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_HOME_GO   = 5'd2;
   localparam logic [4:0] S_HOME_WAIT = 5'd3;
   localparam logic [4:0] S_FIND_RD   = 5'd4;
   localparam logic [4:0] S_FIND_CHK  = 5'd5;
   localparam logic [4:0] S_DISPATCH  = 5'd6;
   localparam logic [4:0] S_INS_RD    = 5'd7;
   localparam logic [4:0] S_INS_CHK   = 5'd8;
   localparam logic [4:0] S_FREE_RD   = 5'd9;
   localparam logic [4:0] S_FREE_CHK  = 5'd10;
   localparam logic [4:0] S_OTH_GO    = 5'd11;
   localparam logic [4:0] S_OTH_WAIT  = 5'd12;
   localparam logic [4:0] S_WALK_RD   = 5'd13;
   localparam logic [4:0] S_WALK_CHK  = 5'd14;
   localparam logic [4:0] S_WR_CUR    = 5'd15;
   localparam logic [4:0] S_WR_F      = 5'd16;
   localparam logic [4:0] S_WR_LINKMP = 5'd17;
   localparam logic [4:0] S_WR_MP     = 5'd18;
   localparam logic [4:0] S_SCAN_RD   = 5'd19;
   localparam logic [4:0] S_SCAN_CHK  = 5'd20;
   localparam logic [4:0] S_DONE      = 5'd21;

   logic [4:0]            state_ff, state_in;
   logic [LOG2_BITS-1:0]  size_ff, size_in;
   logic [COUNT_BITS-1:0] fp_ff, fp_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  sweep_rsp_ff, sweep_rsp_in;

   logic [1:0]            cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   k_ff, k_in;
   logic [VAL_BITS-1:0]   v_ff, v_in;
   logic                  vp_ff, vp_in;

   logic [COUNT_BITS-1:0] cur_ff, cur_in;
   logic [COUNT_BITS-1:0] steps_ff, steps_in;
   logic [SLOT_BITS-1:0]  home_ff, home_in;
   logic [SLOT_BITS-1:0]  f_ff, f_in;
   logic [SLOT_BITS-1:0]  tgt_ff, tgt_in;
   logic                  lnk_has_ff, lnk_has_in;
   logic [SLOT_BITS-1:0]  lnk_next_ff, lnk_next_in;
   logic                  found_ff, found_in;
   logic [KEY_BITS-1:0]   sv_key_ff, sv_key_in;
   logic [VAL_BITS-1:0]   sv_val_ff, sv_val_in;
   meta_type              sv_meta_ff, sv_meta_in;
   meta_type              wm_ff, wm_in;

   logic [2:0]            res_status_ff, res_status_in;
   logic [KEY_BITS-1:0]   res_key_ff, res_key_in;
   logic [VAL_BITS-1:0]   res_val_ff, res_val_in;

   logic                  out_valid_ff, out_valid_in;
   logic [2:0]            out_status_ff, out_status_in;
   logic [KEY_BITS-1:0]   out_key_ff, out_key_in;
   logic [VAL_BITS-1:0]   out_val_ff, out_val_in;
   logic [COUNT_BITS-1:0] out_count_ff, out_count_in;

   mem_req_type           mreq;
   logic [KEY_BITS-1:0]   q_key;
   logic [VAL_BITS-1:0]   q_val;
   meta_type              q_meta;

   logic                  mod_start;
   logic [KEY_BITS-1:0]   mod_key;
   logic                  mod_done;
   logic [SLOT_BITS-1:0]  mod_home;

   logic [COUNT_BITS-1:0] n_slots;
   logic [COUNT_BITS-1:0] fp_dec;
   logic                  req_take;
   logic                  csr_take;

   assign n_slots   = COUNT_BITS'(1) << size_ff;
   assign fp_dec    = fp_ff - COUNT_BITS'(1);
   assign req_stall = (state_ff != S_IDLE);
   // an offered item goes first
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign mod_start = (state_ff == S_HOME_GO) || (state_ff == S_OTH_GO);
   assign mod_key   = (state_ff == S_OTH_GO) ? sv_key_ff : k_ff;

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_key_out    = out_key_ff;
   assign rsp_value_out  = out_val_ff;
   assign rsp_live_count = out_count_ff;

   csht_table u_table (
      .clock  (clock),
      .req    (mreq),
      .q_key  (q_key),
      .q_val  (q_val),
      .q_meta (q_meta)
   );

   csht_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .key       (mod_key),
      .size_log2 (size_ff),
      .done      (mod_done),
      .home      (mod_home)
   );

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      fp_in         = fp_ff;
      count_in      = count_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      cmd_in        = cmd_ff;
      k_in          = k_ff;
      v_in          = v_ff;
      vp_in         = vp_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      home_in       = home_ff;
      f_in          = f_ff;
      tgt_in        = tgt_ff;
      lnk_has_in    = lnk_has_ff;
      lnk_next_in   = lnk_next_ff;
      found_in      = found_ff;
      sv_key_in     = sv_key_ff;
      sv_val_in     = sv_val_ff;
      sv_meta_in    = sv_meta_ff;
      wm_in         = wm_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_val_in    = res_val_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_key_in    = out_key_ff;
      out_val_in    = out_val_ff;
      out_count_in  = out_count_ff;
      mreq          = '0;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_SWEEP: begin
            mreq.we_meta = 1'b1;
            mreq.addr    = cur_ff[SLOT_BITS-1:0];
            cur_in       = cur_ff + COUNT_BITS'(1);
            if (cur_ff == n_slots - COUNT_BITS'(1)) begin
               fp_in    = n_slots;
               count_in = '0;
               state_in = sweep_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (csr_take) begin
               if (csr_size_log2 < MIN_LOG2) begin
                  size_in = MIN_LOG2;
               end else if (csr_size_log2 > MAX_LOG2) begin
                  size_in = MAX_LOG2;
               end else begin
                  size_in = csr_size_log2;
               end
               cur_in       = '0;
               sweep_rsp_in = 1'b0;
               state_in     = S_SWEEP;
            end else if (req_take) begin
               cmd_in        = req_command;
               k_in          = req_key;
               v_in          = req_value;
               vp_in         = req_value_present;
               res_status_in = ST_OK;
               res_key_in    = '0;
               res_val_in    = '0;
               cur_in        = '0;
               case (req_command)
                  CMD_CLEAR: begin
                     sweep_rsp_in = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  CMD_TRAV: begin
                     state_in = req_start_req ? S_SCAN_RD : S_HOME_GO;
                  end
                  default: begin
                     state_in = S_HOME_GO;
                  end
               endcase
            end
         end
         S_HOME_GO: begin
            state_in = S_HOME_WAIT;
         end
         S_HOME_WAIT: begin
            if (mod_done) begin
               home_in  = mod_home;
               cur_in   = COUNT_BITS'(mod_home);
               steps_in = '0;
               state_in = S_FIND_RD;
            end
         end
         S_FIND_RD: begin
            mreq.addr = cur_ff[SLOT_BITS-1:0];
            state_in  = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            sv_key_in  = q_key;
            sv_val_in  = q_val;
            sv_meta_in = q_meta;
            if (q_meta.used && (q_key == k_ff)) begin
               found_in = 1'b1;
               state_in = S_DISPATCH;
            end else if (!q_meta.has_next || (steps_ff + COUNT_BITS'(1) >= n_slots)) begin
               found_in = 1'b0;
               state_in = S_DISPATCH;
            end else begin
               cur_in   = COUNT_BITS'(q_meta.next);
               steps_in = steps_ff + COUNT_BITS'(1);
               state_in = S_FIND_RD;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (cmd_ff)
               CMD_GET: begin
                  if (found_ff && sv_meta_ff.present) begin
                     res_val_in = sv_val_ff;
                  end else begin
                     res_status_in = ST_ABSENT;
                  end
               end
               CMD_SET: begin
                  if (found_ff) begin
                     mreq.addr = cur_ff[SLOT_BITS-1:0];
                     mreq.meta = sv_meta_ff;
                     if (vp_ff) begin
                        mreq.we_val       = 1'b1;
                        mreq.we_meta      = 1'b1;
                        mreq.val          = v_ff;
                        mreq.meta.present = 1'b1;
                        if (!sv_meta_ff.present) begin
                           count_in = count_ff + COUNT_BITS'(1);
                        end
                     end else if (sv_meta_ff.present) begin
                        mreq.we_meta      = 1'b1;
                        mreq.meta.present = 1'b0;
                        count_in          = count_ff - COUNT_BITS'(1);
                     end
                  end else if (!vp_ff) begin
                     res_status_in = ST_ABSENT;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end
               default: begin
                  if (found_ff) begin
                     cur_in   = cur_ff + COUNT_BITS'(1);
                     state_in = S_SCAN_RD;
                  end else begin
                     res_status_in = ST_BAD_KEY;
                  end
               end
            endcase
         end
         S_INS_RD: begin
            mreq.addr = home_ff;
            state_in  = S_INS_CHK;
         end
         S_INS_CHK: begin
            sv_key_in  = q_key;
            sv_val_in  = q_val;
            sv_meta_in = q_meta;
            if (!q_meta.present) begin
               // home slot has no live value: take it, keep its link
               tgt_in      = home_ff;
               lnk_has_in  = q_meta.has_next;
               lnk_next_in = q_meta.next;
               state_in    = S_WR_MP;
            end else begin
               state_in = S_FREE_RD;
            end
         end
         S_FREE_RD: begin
            if (fp_ff == '0) begin
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end else begin
               mreq.addr = fp_dec[SLOT_BITS-1:0];
               fp_in     = fp_dec;
               state_in  = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            if (!q_meta.used) begin
               f_in     = fp_ff[SLOT_BITS-1:0];
               state_in = S_OTH_GO;
            end else begin
               state_in = S_FREE_RD;
            end
         end
         S_OTH_GO: begin
            state_in = S_OTH_WAIT;
         end
         S_OTH_WAIT: begin
            if (mod_done) begin
               if (mod_home != home_ff) begin
                  cur_in   = COUNT_BITS'(mod_home);
                  steps_in = '0;
                  state_in = S_WALK_RD;
               end else begin
                  state_in = S_WR_LINKMP;
               end
            end
         end
         S_WALK_RD: begin
            mreq.addr = cur_ff[SLOT_BITS-1:0];
            state_in  = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            wm_in = q_meta;
            // find the predecessor of the home slot in the occupant's chain
            if ((steps_ff < n_slots) && q_meta.has_next && (q_meta.next != home_ff)) begin
               cur_in   = COUNT_BITS'(q_meta.next);
               steps_in = steps_ff + COUNT_BITS'(1);
               state_in = S_WALK_RD;
            end else begin
               state_in = S_WR_CUR;
            end
         end
         S_WR_CUR: begin
            mreq.we_meta       = 1'b1;
            mreq.addr          = cur_ff[SLOT_BITS-1:0];
            mreq.meta          = wm_ff;
            mreq.meta.has_next = 1'b1;
            mreq.meta.next     = f_ff;
            state_in           = S_WR_F;
         end
         S_WR_F: begin
            // move the occupant to the free slot
            mreq.we_key  = 1'b1;
            mreq.we_val  = 1'b1;
            mreq.we_meta = 1'b1;
            mreq.addr    = f_ff;
            mreq.key     = sv_key_ff;
            mreq.val     = sv_val_ff;
            mreq.meta    = sv_meta_ff;
            tgt_in       = home_ff;
            lnk_has_in   = 1'b0;
            lnk_next_in  = '0;
            state_in     = S_WR_MP;
         end
         S_WR_LINKMP: begin
            mreq.we_meta       = 1'b1;
            mreq.addr          = home_ff;
            mreq.meta          = sv_meta_ff;
            mreq.meta.has_next = 1'b1;
            mreq.meta.next     = f_ff;
            tgt_in             = f_ff;
            lnk_has_in         = sv_meta_ff.has_next;
            lnk_next_in        = sv_meta_ff.has_next ? sv_meta_ff.next : '0;
            state_in           = S_WR_MP;
         end
         S_WR_MP: begin
            mreq.we_key        = 1'b1;
            mreq.we_val        = 1'b1;
            mreq.we_meta       = 1'b1;
            mreq.addr          = tgt_ff;
            mreq.key           = k_ff;
            mreq.val           = v_ff;
            mreq.meta.used     = 1'b1;
            mreq.meta.present  = 1'b1;
            mreq.meta.has_next = lnk_has_ff;
            mreq.meta.next     = lnk_next_ff;
            count_in           = count_ff + COUNT_BITS'(1);
            state_in           = S_DONE;
         end
         S_SCAN_RD: begin
            if (cur_ff >= n_slots) begin
               res_status_in = ST_TRAV_END;
               state_in      = S_DONE;
            end else begin
               mreq.addr = cur_ff[SLOT_BITS-1:0];
               state_in  = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (q_meta.present) begin
               res_status_in = ST_OK;
               res_key_in    = q_key;
               res_val_in    = q_val;
               state_in      = S_DONE;
            end else begin
               cur_in   = cur_ff + COUNT_BITS'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in  = 1'b1;
               out_status_in = sweep_rsp_ff ? ST_OK : res_status_ff;
               out_key_in    = sweep_rsp_ff ? '0 : res_key_ff;
               out_val_in    = sweep_rsp_ff ? '0 : res_val_ff;
               out_count_in  = count_ff;
               sweep_rsp_in  = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         size_ff      <= MAX_LOG2;
         fp_ff        <= '0;
         count_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         cur_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         fp_ff        <= fp_in;
         count_ff     <= count_in;
         sweep_rsp_ff <= sweep_rsp_in;
         cur_ff       <= cur_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff        <= cmd_in;
      k_ff          <= k_in;
      v_ff          <= v_in;
      vp_ff         <= vp_in;
      steps_ff      <= steps_in;
      home_ff       <= home_in;
      f_ff          <= f_in;
      tgt_ff        <= tgt_in;
      lnk_has_ff    <= lnk_has_in;
      lnk_next_ff   <= lnk_next_in;
      found_ff      <= found_in;
      sv_key_ff     <= sv_key_in;
      sv_val_ff     <= sv_val_in;
      sv_meta_ff    <= sv_meta_in;
      wm_ff         <= wm_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_val_ff    <= res_val_in;
      out_status_ff <= out_status_in;
      out_key_ff    <= out_key_in;
      out_val_ff    <= out_val_in;
      out_count_ff  <= out_count_in;
   end

endmodule

### rtl/csht_checker.sv
module csht_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [2:0]                       rsp_status,
   input logic signed [63:0]               rsp_key_out,
   input logic [63:0]                      rsp_value_out,
   input logic [10:0]                      rsp_live_count,
   input logic                             csr_valid,
   input logic                             csr_ready
);
   import csht_pkg::*;

   // config and items are taken in the same idle window
   assert property (@(posedge clock) disable iff (reset) csr_ready |-> !req_stall)
      else $error("csr_ready without req ready");

   // a config write starts a sweep: nothing is taken the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (req_stall && !csr_ready))
      else $error("item taken right after config write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_live_count <= 11'd1024 && rsp_status <= ST_TRAV_END))
      else $error("response out of range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_TRAV_END || rsp_status == ST_BAD_KEY
                     || rsp_status == ST_FULL))
      |-> (rsp_key_out == '0 && rsp_value_out == '0))
      else $error("payload not zero on failing status");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind chained_scatter_hash_table csht_checker u_csht_checker (.*);
